// File: sv/lpcd_pkg.sv
// Package: shared types and constants for the LPC bus cycle decoder.
`default_nettype none
package lpcd_pkg;

  typedef struct packed {
    logic       lframe_n;
    logic [3:0] lad;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [1:0]  index;
    logic [2:0]  warn_code;
    logic        last;
  } out_item_t;

  localparam logic [3:0] K_START   = 4'd0;
  localparam logic [3:0] K_CTYPE   = 4'd1;
  localparam logic [3:0] K_ADDR    = 4'd2;
  localparam logic [3:0] K_IDSEL   = 4'd3;
  localparam logic [3:0] K_MSIZE   = 4'd4;
  localparam logic [3:0] K_TAR1    = 4'd5;
  localparam logic [3:0] K_SYNC    = 4'd6;
  localparam logic [3:0] K_TIMEOUT = 4'd7;
  localparam logic [3:0] K_DATA    = 4'd8;
  localparam logic [3:0] K_TAR2    = 4'd9;
  localparam logic [3:0] K_WARN    = 4'd10;

  localparam logic [2:0] W_NONE  = 3'd0;
  localparam logic [2:0] W_TAR   = 3'd1;
  localparam logic [2:0] W_SYNC  = 3'd2;
  localparam logic [2:0] W_ABORT = 3'd3;
  localparam logic [2:0] W_MSIZE = 3'd4;

  localparam int unsigned QueueDepth = 4;

  // One decoded sample: up to two results.
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } pair_t;

endpackage
`default_nettype wire

// File: sv/lpcd_front.sv
// Front part: decodes each bus sample into zero, one or two results.
`default_nettype none
module lpcd_front
  import lpcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          p_valid,
  output pair_t         p_data,
  input  wire logic     p_full
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_CTDR, PH_ADDR, PH_IDSEL, PH_FWADDR, PH_MSIZE,
    PH_TAR, PH_SYNC, PH_TIMEOUT, PH_FWDATA, PH_DATA, PH_TAR2
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic        prev_frame, prev_nibble_valid;
  logic [3:0]  prev_nibble;
  logic [3:0]  start_code, start_next, cycle_code, cycle_next, mem_size_code, msz_next;
  logic        is_write, wr_next;
  logic [31:0] address_acc, addr_next;
  logic [7:0]  nibble_count, cnt_next;
  logic [7:0]  byte_acc, byte_next;
  logic [63:0] word_acc, word_next;
  logic        half_count, half_next, turn_count, turn_next;
  logic [1:0]  abort_count, abort_next;

  out_item_t   r [2];
  logic [1:0]  nres;
  logic        take;
  logic [3:0]  nb;
  logic        lf;
  logic [8:0]  n;
  logic [10:0] off;

  assign in_stall = p_full;
  assign take     = in_valid && !p_full;
  assign nb       = prev_nibble;
  assign lf       = in_data.lframe_n;

  function automatic out_item_t mk(logic [3:0] k, logic [63:0] v, logic [1:0] i,
                                   logic [2:0] w);
    out_item_t o;
    o.kind = k; o.value = v; o.index = i; o.warn_code = w; o.last = 1'b0;
    return o;
  endfunction

  always_comb begin
    phase_next = phase;
    start_next = start_code; cycle_next = cycle_code; msz_next = mem_size_code;
    wr_next = is_write; addr_next = address_acc; cnt_next = nibble_count;
    byte_next = byte_acc; word_next = word_acc; half_next = half_count;
    turn_next = turn_count; abort_next = abort_count;
    r[0] = mk(K_START, 64'd0, 2'd0, W_NONE); r[1] = r[0];
    nres = 2'd0; n = 9'd0; off = 11'd0;
    ph = (!lf && !prev_frame) ? PH_TIMEOUT : phase;
    phase_next = ph;
    case (ph)
      PH_IDLE: if (!lf) phase_next = PH_START;
      PH_START: begin
        if (prev_nibble_valid) begin
          r[0] = mk(K_START, {60'd0, nb}, 2'd0, W_NONE); nres = 2'd1;
        end
        if (lf) begin
          if (prev_nibble_valid && (nb == 4'h0 || nb == 4'h5)) begin
            start_next = nb; phase_next = PH_CTDR;
          end else if (prev_nibble_valid && (nb == 4'hD || nb == 4'hE)) begin
            start_next = nb; wr_next = (nb == 4'hE); phase_next = PH_IDSEL;
          end else phase_next = PH_IDLE;
        end
      end
      PH_CTDR: begin
        cycle_next = nb; wr_next = (nb < 4'hC) && nb[1];
        r[0] = mk(K_CTYPE, {60'd0, nb}, 2'd0, W_NONE); nres = 2'd1;
        phase_next = PH_ADDR; addr_next = '0; cnt_next = '0;
      end
      PH_ADDR: begin
        n = (cycle_code <= 4'd3) ? 9'd4 : (cycle_code <= 4'd7) ? 9'd8 : 9'd0;
        if (n == 9'd0) begin
          if (is_write) begin phase_next = PH_DATA; half_next = 1'b0; end
          else begin phase_next = PH_TAR; turn_next = 1'b0; end
        end else if ({1'b0, nibble_count} > n - 9'd1) phase_next = PH_IDLE;
        else begin
          addr_next = address_acc |
                      (32'(nb) << (5'(n[3:0] - 4'd1 - nibble_count[3:0]) * 5'd4));
          if ({1'b0, nibble_count} < n - 9'd1) cnt_next = nibble_count + 8'd1;
          else begin
            r[0] = mk(K_ADDR, {32'd0, addr_next}, 2'd0, W_NONE); nres = 2'd1;
            if (is_write) begin phase_next = PH_DATA; half_next = 1'b0; end
            else begin phase_next = PH_TAR; turn_next = 1'b0; end
          end
        end
      end
      PH_IDSEL: begin
        r[0] = mk(K_IDSEL, {60'd0, nb}, 2'd0, W_NONE); nres = 2'd1;
        phase_next = PH_FWADDR; addr_next = '0; cnt_next = '0;
      end
      PH_FWADDR: begin
        if (nibble_count > 8'd6) phase_next = PH_IDLE;
        else begin
          addr_next = address_acc |
                      (32'(nb) << (5'(3'd6 - nibble_count[2:0]) * 5'd4));
          if (nibble_count < 8'd6) cnt_next = nibble_count + 8'd1;
          else begin
            r[0] = mk(K_ADDR, {32'd0, addr_next}, 2'd0, W_NONE); nres = 2'd1;
            phase_next = PH_MSIZE;
          end
        end
      end
      PH_MSIZE: begin
        r[0] = mk(K_MSIZE, {60'd0, nb}, 2'd0, W_NONE); nres = 2'd1;
        msz_next = nb;
        if (is_write) begin phase_next = PH_FWDATA; cnt_next = '0; word_next = '0; end
        else begin phase_next = PH_TAR; turn_next = 1'b0; end
      end
      PH_TAR, PH_TAR2: begin
        r[0] = mk((ph == PH_TAR) ? K_TAR1 : K_TAR2, {60'd0, nb}, {1'b0, turn_count},
                  W_NONE);
        r[1] = mk(K_WARN, {60'd0, nb}, {1'b0, turn_count}, W_TAR);
        nres = (nb != 4'hF) ? 2'd2 : 2'd1;
        if (!turn_count) turn_next = 1'b1;
        else begin
          turn_next = 1'b0;
          phase_next = (ph == PH_TAR) ? PH_SYNC : PH_IDLE;
        end
      end
      PH_SYNC: begin
        r[0] = mk(K_SYNC, {60'd0, nb}, 2'd0, W_NONE);
        r[1] = mk(K_WARN, {60'd0, nb}, 2'd0, W_SYNC);
        nres = (nb == 4'h0 || nb == 4'h5 || nb == 4'h6 || nb == 4'h9 || nb == 4'hA)
               ? 2'd1 : 2'd2;
        if (nb != 4'h5 && nb != 4'h6) begin
          half_next = 1'b0;
          if (!lf) phase_next = PH_TIMEOUT;
          else if (start_code == 4'hD || start_code == 4'hE) begin
            phase_next = PH_FWDATA; cnt_next = '0; word_next = '0;
          end else phase_next = PH_DATA;
        end
      end
      PH_TIMEOUT: begin
        nres = 2'd1;
        if (prev_frame) begin
          r[0] = mk(K_WARN, 64'd0, 2'd0, W_ABORT);
          abort_next = 2'd0; phase_next = PH_IDLE;
        end else begin
          r[0] = mk(K_TIMEOUT, 64'd0, abort_count, W_NONE);
          abort_next = abort_count + 2'd1;
          if (abort_count == 2'd3) phase_next = PH_IDLE;
        end
      end
      PH_FWDATA: begin
        case (mem_size_code)
          4'h0: n = 9'd2;
          4'h1: n = 9'd4;
          4'h2: n = 9'd8;
          4'h4: n = 9'd32;
          4'h7: n = 9'd256;
          default: n = 9'd0;
        endcase
        if (n == 9'd0) begin
          r[0] = mk(K_WARN, {60'd0, mem_size_code}, 2'd0, W_MSIZE); nres = 2'd1;
          phase_next = PH_IDLE;
        end else if ({1'b0, nibble_count} > n - 9'd1) phase_next = PH_IDLE;
        else begin
          off = {(n - 9'd1 - {1'b0, nibble_count}), 2'b00};
          off = nibble_count[0] ? off + 11'd4 : off - 11'd4;
          if (off < 11'd64) word_next = word_acc | (64'(nb) << off[5:0]);
          if ({1'b0, nibble_count} < n - 9'd1) cnt_next = nibble_count + 8'd1;
          else begin
            r[0] = mk(K_DATA, word_next, 2'd0, W_NONE); nres = 2'd1;
            half_next = 1'b0; phase_next = PH_TAR2;
          end
        end
      end
      PH_DATA: begin
        if (!half_count) begin byte_next = {4'd0, nb}; half_next = 1'b1; end
        else begin
          byte_next = {nb, byte_acc[3:0]};
          r[0] = mk(K_DATA, {56'd0, byte_next}, 2'd0, W_NONE); nres = 2'd1;
          half_next = 1'b0; phase_next = PH_TAR2;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    if (nres == 2'd1) r[0].last = 1'b1;
    if (nres == 2'd2) r[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; prev_frame <= 1'b1; prev_nibble <= '0;
      prev_nibble_valid <= 1'b0; start_code <= '0; cycle_code <= '0;
      is_write <= 1'b0; mem_size_code <= '0; address_acc <= '0;
      nibble_count <= '0; byte_acc <= '0; word_acc <= '0; half_count <= 1'b0;
      turn_count <= 1'b0; abort_count <= '0; p_valid <= 1'b0;
    end else begin
      p_valid <= take && (nres != 2'd0);
      if (take) begin
        phase <= phase_next; prev_frame <= lf; prev_nibble <= in_data.lad;
        prev_nibble_valid <= 1'b1; start_code <= start_next; cycle_code <= cycle_next;
        is_write <= wr_next; mem_size_code <= msz_next; address_acc <= addr_next;
        nibble_count <= cnt_next; byte_acc <= byte_next; word_acc <= word_next;
        half_count <= half_next; turn_count <= turn_next; abort_count <= abort_next;
        p_data.two <= (nres == 2'd2);
        p_data.r0  <= r[0];
        p_data.r1  <= r[1];
      end
    end
  end

  a_stall: assert property (@(posedge clk) disable iff (rst)
    p_full |=> !p_valid) else $error("front wrote while queue full");
  a_pnv: assert property (@(posedge clk) disable iff (rst)
    $past(take) |-> prev_nibble_valid) else $error("nibble not marked valid");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    (p_valid && p_data.two) |-> p_data.r1.last && !p_data.r0.last)
    else $error("last flag misplaced");

endmodule
`default_nettype wire

// File: sv/lpcd_back.sv
// Back part: queue of decoded samples and result serializer.
`default_nettype none
module lpcd_back
  import lpcd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      p_valid,
  input  wire pair_t     p_data,
  output logic           p_full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  pair_t         mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          sel;
  logic          pop, done;

  // Full leaves room for the entry arriving from the front register.
  assign p_full    = (cnt >= (AW+1)'(Depth - 1));
  assign out_valid = (cnt != '0);
  assign out_data  = sel ? mem[rp].r1 : mem[rp].r0;
  assign pop       = out_valid && !out_stall;
  assign done      = pop && (sel || !mem[rp].two);

  always_ff @(posedge clk) begin
    if (p_valid) mem[wp] <= p_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; sel <= 1'b0;
    end else begin
      if (p_valid) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + AW'(1);
      if (done) begin
        rp  <= (rp == AW'(Depth - 1)) ? '0 : rp + AW'(1);
        sel <= 1'b0;
      end else if (pop) sel <= 1'b1;
      cnt <= cnt + (AW+1)'(p_valid) - (AW+1)'(done);
    end
  end

  a_over: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> cnt < (AW+1)'(Depth)) else $error("queue overflow");
  a_sel: assert property (@(posedge clk) disable iff (rst)
    sel |-> out_valid && mem[rp].two) else $error("second half without pair");
  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> out_data.last) else $error("request retired without last");

endmodule
`default_nettype wire

// File: sv/lpc_bus_cycle_decoder.sv
// Top level: LPC bus cycle decoder.
// Takes one LFRAME#/LAD sample per cycle while in_stall is low and reports the
// decoded fields one sample late; a sample gives up to two results, each a
// request on the out channel. Input is accepted every cycle while the output
// side keeps up; the front decoder has one register stage, results pass through
// a queue of Depth decoded samples, and a two-result sample goes out r0 first.
`default_nettype none
module lpc_bus_cycle_decoder
  import lpcd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic  p_valid, p_full;
  pair_t p_data;

  lpcd_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .p_valid, .p_data, .p_full
  );

  lpcd_back #(.Depth(Depth)) u_back (
    .clk, .rst, .p_valid, .p_data, .p_full, .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire
